FILE: design/sbfr_pkg.sv
// sbfr_pkg: shared types and constants for the serial bit frame receiver.
// Used by the decoder, the result queue, the top level and the checker.
package sbfr_pkg;

    localparam int SENDER_W = 22;
    localparam int LEN_W    = 32;
    localparam int BYTE_W   = 8;
    localparam int LEFT_W   = 31;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   data;
        logic [SENDER_W-1:0] target;
        logic                last;
    } result_t;

endpackage

FILE: design/sbfr_decoder.sv
// sbfr_decoder: frame state machine; consumes one bit per step and emits
// zero, one or two results. Depends on sbfr_pkg.
module sbfr_decoder
    import sbfr_pkg::*;
#(
    parameter int HEADER_WORD_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic                bit_value,
    input  logic [SENDER_W-1:0] sender_id,
    output logic [1:0]          res_cnt,
    output result_t             res0,
    output result_t             res1
);

    localparam int WC_W = $clog2(HEADER_WORD_BITS);

    typedef enum logic [1:0] {
        PH_SENDER  = 2'd0,
        PH_LENGTH  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   byte_shift_reg, byte_shift_next;
    logic [2:0]          bit_count_reg, bit_count_next;
    logic [WC_W-1:0]     word_count_reg, word_count_next;
    logic [LEN_W-1:0]    length_word_reg, length_word_next;
    logic [LEFT_W-1:0]   bytes_left_reg, bytes_left_next;

    logic                wc_done;
    logic [LEN_W-1:0]    len_shift;
    logic                len_zero;
    logic [LEFT_W-1:0]   left_dec;
    logic [BYTE_W-1:0]   byte_in;

    assign wc_done   = (word_count_reg == WC_W'(HEADER_WORD_BITS - 1));
    assign len_shift = {length_word_reg[LEN_W-2:0], bit_value};
    assign len_zero  = len_shift[LEN_W-1] || (len_shift[LEN_W-2:0] == '0);
    assign left_dec  = bytes_left_reg - LEFT_W'(1);
    assign byte_in   = {byte_shift_reg[BYTE_W-2:0], bit_value};

    always_comb
    begin
        phase_next       = phase_reg;
        byte_shift_next  = byte_shift_reg;
        bit_count_next   = bit_count_reg;
        word_count_next  = word_count_reg;
        length_word_next = length_word_reg;
        bytes_left_next  = bytes_left_reg;
        res_cnt          = 2'd0;
        res0             = '0;
        res1             = '0;

        if (step)
        begin
            case (phase_reg)
                PH_LENGTH:
                begin
                    if (wc_done)
                    begin
                        word_count_next  = '0;
                        byte_shift_next  = '0;
                        bit_count_next   = '0;
                        length_word_next = '0;
                        if (len_zero)
                        begin
                            phase_next  = PH_SENDER;
                            res_cnt     = 2'd1;
                            res0.kind   = KIND_ACK;
                            res0.target = sender_id;
                            res0.last   = 1'b1;
                        end
                        else
                        begin
                            bytes_left_next = len_shift[LEFT_W-1:0];
                            phase_next      = PH_PAYLOAD;
                        end
                    end
                    else
                    begin
                        word_count_next  = word_count_reg + WC_W'(1);
                        length_word_next = len_shift;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (bit_count_reg == 3'd7)
                    begin
                        byte_shift_next = '0;
                        bit_count_next  = '0;
                        bytes_left_next = left_dec;
                        res0.kind       = KIND_BYTE;
                        res0.data       = byte_in;
                        if (left_dec == '0)
                        begin
                            phase_next  = PH_SENDER;
                            res_cnt     = 2'd2;
                            res1.kind   = KIND_ACK;
                            res1.target = sender_id;
                            res1.last   = 1'b1;
                        end
                        else
                        begin
                            res_cnt   = 2'd1;
                            res0.last = 1'b1;
                        end
                    end
                    else
                    begin
                        bit_count_next  = bit_count_reg + 3'd1;
                        byte_shift_next = byte_in;
                    end
                end
                default:
                begin
                    if (wc_done)
                    begin
                        word_count_next  = '0;
                        byte_shift_next  = '0;
                        bit_count_next   = '0;
                        length_word_next = '0;
                        phase_next       = PH_LENGTH;
                    end
                    else
                    begin
                        word_count_next = word_count_reg + WC_W'(1);
                        phase_next      = PH_SENDER;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_SENDER;
            byte_shift_reg  <= '0;
            bit_count_reg   <= '0;
            word_count_reg  <= '0;
            length_word_reg <= '0;
            bytes_left_reg  <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            byte_shift_reg  <= byte_shift_next;
            bit_count_reg   <= bit_count_next;
            word_count_reg  <= word_count_next;
            length_word_reg <= length_word_next;
            bytes_left_reg  <= bytes_left_next;
        end
    end

endmodule

FILE: design/sbfr_result_fifo.sv
// sbfr_result_fifo: four-entry result queue, up to two pushes and one pop
// per cycle. Depends on sbfr_pkg.
module sbfr_result_fifo
    import sbfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] push_cnt,
    input  result_t    push0,
    input  result_t    push1,
    output logic       has_room2,
    output logic       head_valid,
    input  logic       head_pop,
    output result_t    head
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = PTR_W + 1;

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign head_valid = (count_reg != '0);
    assign has_room2  = (count_reg <= CNT_W'(DEPTH - 2));
    assign pop        = head_valid && head_pop;
    assign head       = mem[rd_ptr_reg];
    assign count_next = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(pop);
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/serial_bit_frame_receiver_top.sv
// serial_bit_frame_receiver_top: bit-serial, length-prefixed frame receiver.
// Depends on sbfr_pkg, sbfr_decoder and sbfr_result_fifo.
//
// One bit beat is taken every cycle while the input is not stalled. Each beat
// is held in an input register and decoded once the queue has room for two
// results; its results (a payload byte, an acknowledge, or a byte followed by
// an acknowledge) land in a four-entry output queue and leave one beat per
// cycle while out_ready is high. A frame is a HEADER_WORD_BITS sender word,
// a HEADER_WORD_BITS length word (bit 31 set means zero) and that many bytes.
// Input stalls only when the queue cannot take two more results.
module serial_bit_frame_receiver_top
    import sbfr_pkg::*;
#(
    parameter int HEADER_WORD_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                bit_value,
    input  logic [SENDER_W-1:0] sender_id,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                result_kind,
    output logic [BYTE_W-1:0]   data_byte,
    output logic [SENDER_W-1:0] ack_target,
    output logic                last_of_run
);

    logic                in_full_reg;
    logic                bit_reg;
    logic [SENDER_W-1:0] sender_reg;
    logic                step;
    logic                has_room2;
    logic [1:0]          res_cnt;
    result_t             res0, res1, head;

    assign step     = in_full_reg && has_room2;
    assign in_ready = !in_full_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            bit_reg    <= bit_value;
            sender_reg <= sender_id;
        end
    end

    sbfr_decoder #(
        .HEADER_WORD_BITS(HEADER_WORD_BITS)
    ) u_decoder (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .bit_value (bit_reg),
        .sender_id (sender_reg),
        .res_cnt   (res_cnt),
        .res0      (res0),
        .res1      (res1)
    );

    sbfr_result_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (res_cnt),
        .push0      (res0),
        .push1      (res1),
        .has_room2  (has_room2),
        .head_valid (out_valid),
        .head_pop   (out_ready),
        .head       (head)
    );

    assign result_kind = head.kind;
    assign data_byte   = head.data;
    assign ack_target  = head.target;
    assign last_of_run = head.last;

endmodule

FILE: design/sbfr_checker.sv
// sbfr_checker: port-level assertions for serial_bit_frame_receiver_top,
// attached by bind. Depends on sbfr_pkg.
module sbfr_checker
    import sbfr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic                result_kind,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic [SENDER_W-1:0] ack_target,
    input  logic                last_of_run
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
            && $stable(data_byte) && $stable(ack_target) && $stable(last_of_run))
        else $error("result beat changed while stalled");

    a_ack_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_ACK |-> data_byte == '0 && last_of_run)
        else $error("acknowledge beat malformed");

    a_byte_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == KIND_BYTE |-> ack_target == '0)
        else $error("payload beat carries a target");

    // final byte of a frame is always followed by its acknowledge
    a_byte_then_ack: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && result_kind == KIND_BYTE && !last_of_run
            |=> out_valid && result_kind == KIND_ACK)
        else $error("missing acknowledge after last byte");

endmodule

bind serial_bit_frame_receiver_top sbfr_checker u_sbfr_checker (.*);
